>>> rtl/pse_pkg.sv
// pse_pkg: shared types and constants of the postfix stack evaluator
// no dependencies; imported by the interfaces, pse_ctrl, pse_datapath and the top level
`default_nettype none

package pse_pkg;

  localparam int VAL_W = 32;
  localparam int ITER_W = 6;   // holds the longest iteration count (32)

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_OPER = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  localparam logic [ITER_W-1:0] DIV_STEPS = ITER_W'(32);
  localparam logic [ITER_W-1:0] POW_STEPS = ITER_W'(31);

  // controller to datapath
  typedef struct packed {
    logic load_tok;
    logic push_tok;
    logic push_res;
    logic pop;
    logic take_right;
    logic take_left;
    logic alu_start;
    logic alu_step;
    logic load_out;
  } pse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] tok_req;
    logic [2:0] tok_op;
    logic       alu_busy;
    logic       out_free;
  } pse_status_t;

endpackage

`default_nettype wire

>>> rtl/pse_req_if.sv
// pse_req_if: token request channel (valid, ready, token fields)
// depends on pse_pkg
`default_nettype none

interface pse_req_if
  import pse_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [2:0]              operator_code;
  logic signed [VAL_W-1:0] operand_value;

  modport source (output valid, output req_type, output operator_code,
                  output operand_value, input ready);
  modport sink   (input valid, input req_type, input operator_code,
                  input operand_value, output ready);
endinterface

`default_nettype wire

>>> rtl/pse_res_if.sv
// pse_res_if: result request channel (valid, ready, value and sticky flags)
// depends on pse_pkg
`default_nettype none

interface pse_res_if
  import pse_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic                    stack_underflow;
  logic                    stack_overflow;
  logic                    divide_by_zero;

  modport source (output valid, output result_value, output stack_underflow,
                  output stack_overflow, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input stack_underflow,
                  input stack_overflow, input divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> rtl/pse_ram.sv
// pse_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/pse_datapath.sv
// pse_datapath: value stack, stack count, sticky flags, operand registers,
// add, subtract, iterative divide / multiply / power unit, output register
// depends on pse_pkg, pse_ram, pse_res_if
`default_nettype none

module pse_datapath
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       req_type,
  input  wire logic [2:0]       operator_code,
  input  wire logic [VAL_W-1:0] operand_value,
  input  wire pse_cmd_t         cmd,
  output pse_status_t           status,
  pse_res_if.source             result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  // token
  logic [1:0]       tok_req;
  logic [2:0]       tok_op;
  logic [VAL_W-1:0] tok_val;

  // stack control
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_dec;
  logic             full;
  logic             empty;
  logic             pop_empty;
  logic             flag_uf;
  logic             flag_of;
  logic             flag_dz;

  logic             ram_we;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0] pop_val;

  // operands and arithmetic unit
  logic [VAL_W-1:0]  rgt;
  logic [VAL_W-1:0]  lft;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  sq;
  logic [VAL_W-1:0]  rem;
  logic              neg;
  logic [ITER_W-1:0] cnt;
  logic [VAL_W-1:0]  lft_mag;
  logic [VAL_W-1:0]  rgt_mag;
  logic [VAL_W:0]    trial;
  logic [2*VAL_W-1:0] prod_acc;
  logic [2*VAL_W-1:0] prod_sq;
  logic [VAL_W-1:0]  alu_res;

  // output register
  logic             out_valid;
  logic [VAL_W-1:0] out_value;
  logic             out_uf;
  logic             out_of;
  logic             out_dz;

  assign count_dec = count - CW'(1);
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign pop_val   = pop_empty ? '0 : ram_rdata;

  assign ram_we    = (cmd.push_tok || cmd.push_res) && !full;
  assign ram_wdata = cmd.push_tok ? tok_val : alu_res;

  pse_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (count_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign lft_mag  = lft[VAL_W-1] ? (VAL_W'(0) - lft) : lft;
  assign rgt_mag  = rgt[VAL_W-1] ? (VAL_W'(0) - rgt) : rgt;
  assign trial    = {rem, acc[VAL_W-1]} - {1'b0, sq};
  assign prod_acc = (2*VAL_W)'(acc) * (2*VAL_W)'(sq);
  assign prod_sq  = (2*VAL_W)'(sq) * (2*VAL_W)'(sq);
  assign alu_res  = neg ? (VAL_W'(0) - acc) : acc;

  // control state: stack count, flags, iteration count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pop_empty <= 1'b0;
      flag_uf   <= 1'b0;
      flag_of   <= 1'b0;
      flag_dz   <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push_tok || cmd.push_res) begin
        if (full) begin
          flag_of <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.pop) begin
        if (empty) begin
          flag_uf   <= 1'b1;
          pop_empty <= 1'b1;
        end else begin
          count     <= count_dec;
          pop_empty <= 1'b0;
        end
      end
      if (cmd.alu_start) begin
        cnt <= '0;
        case (tok_op)
          OP_MUL: cnt <= ITER_W'(1);
          OP_DIV: begin
            if (rgt == '0) begin
              flag_dz <= 1'b1;
            end else begin
              cnt <= DIV_STEPS;
            end
          end
          OP_POW: begin
            if (rgt[VAL_W-1]) begin
              if (lft == '0) begin
                flag_dz <= 1'b1;
              end
            end else begin
              cnt <= POW_STEPS;
            end
          end
          default: ;
        endcase
      end else if (cmd.alu_step) begin
        cnt <= cnt - ITER_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        count     <= '0;
        flag_uf   <= 1'b0;
        flag_of   <= 1'b0;
        flag_dz   <= 1'b0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      tok_req <= req_type;
      tok_op  <= operator_code;
      tok_val <= operand_value;
    end
    if (cmd.take_right) begin
      rgt <= pop_val;
    end
    if (cmd.take_left) begin
      lft <= pop_val;
    end
    if (cmd.alu_start) begin
      neg <= 1'b0;
      rem <= '0;
      sq  <= rgt;
      case (tok_op)
        OP_ADD: acc <= lft + rgt;
        OP_SUB: acc <= lft - rgt;
        OP_MUL: begin
          // one multiply step with the exponent bit forced on
          acc <= lft;
          rem <= VAL_W'(1);
        end
        OP_DIV: begin
          acc <= (rgt == '0) ? '0 : lft_mag;
          sq  <= rgt_mag;
          neg <= (rgt != '0) && (lft[VAL_W-1] ^ rgt[VAL_W-1]);
        end
        default: begin
          if (rgt[VAL_W-1]) begin
            // negative exponent
            if (lft == VAL_W'(1)) begin
              acc <= VAL_W'(1);
            end else if (lft == '1) begin
              acc <= rgt[0] ? '1 : VAL_W'(1);
            end else begin
              acc <= '0;
            end
          end else begin
            acc <= VAL_W'(1);
            sq  <= lft;
            rem <= rgt;
          end
        end
      endcase
    end else if (cmd.alu_step) begin
      if (tok_op == OP_DIV) begin
        // restoring divide, one quotient bit per step
        if (!trial[VAL_W]) begin
          rem <= trial[VAL_W-1:0];
          acc <= {acc[VAL_W-2:0], 1'b1};
        end else begin
          rem <= {rem[VAL_W-2:0], acc[VAL_W-1]};
          acc <= {acc[VAL_W-2:0], 1'b0};
        end
      end else begin
        // square and multiply, one exponent bit per step
        if (rem[0]) begin
          acc <= prod_acc[VAL_W-1:0];
        end
        sq  <= prod_sq[VAL_W-1:0];
        rem <= {1'b0, rem[VAL_W-1:1]};
      end
    end
    if (cmd.load_out) begin
      out_value <= rgt;
      out_uf    <= flag_uf;
      out_of    <= flag_of;
      out_dz    <= flag_dz;
    end
  end

  assign status.tok_req  = tok_req;
  assign status.tok_op   = tok_op;
  assign status.alu_busy = (cnt != '0);
  assign status.out_free = !out_valid || result.ready;

  assign result.valid           = out_valid;
  assign result.result_value    = out_value;
  assign result.stack_underflow = out_uf;
  assign result.stack_overflow  = out_of;
  assign result.divide_by_zero  = out_dz;

endmodule

`default_nettype wire

>>> rtl/pse_ctrl.sv
// pse_ctrl: token sequencer; decodes one token and steps the datapath
// depends on pse_pkg
`default_nettype none

module pse_ctrl
  import pse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pse_status_t status,
  output pse_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_L,
    S_TAKE_L,
    S_EXEC,
    S_ITER,
    S_TAKE_F,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_tok = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (status.tok_req)
          REQ_PUSH: cmd.push_tok = 1'b1;
          REQ_OPER: begin
            if (status.tok_op <= OP_POW) begin
              cmd.pop    = 1'b1;
              state_next = S_POP_L;
            end
          end
          REQ_END: begin
            cmd.pop    = 1'b1;
            state_next = S_TAKE_F;
          end
          default: ;
        endcase
      end
      S_POP_L: begin
        cmd.take_right = 1'b1;
        cmd.pop        = 1'b1;
        state_next     = S_TAKE_L;
      end
      S_TAKE_L: begin
        cmd.take_left = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu_start = 1'b1;
        state_next    = S_ITER;
      end
      S_ITER: begin
        if (status.alu_busy) begin
          cmd.alu_step = 1'b1;
        end else begin
          cmd.push_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TAKE_F: begin
        cmd.take_right = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/postfix_stack_evaluator.sv
// postfix_stack_evaluator: top level, postfix integer expression evaluator
// depends on pse_pkg, pse_req_if, pse_res_if, pse_ctrl, pse_datapath, pse_ram
//
//  channel  role    carries
//  -------  ------  ------------------------------------------------------------
//  token    sink    req_type, operator_code, operand_value (one token per request)
//  result   source  result_value, stack_underflow, stack_overflow, divide_by_zero
//
// one token at a time; token ready is high only while the sequencer is idle
// push, unused request or unused operator: load and decode, then back to idle
// add / subtract: pop, pop, execute, push; multiply: plus a single multiplier step
// divide: 32-step restoring divider; a zero divisor skips it, sets divide_by_zero
// power: 31 square-and-multiply steps; a negative exponent skips them
// end token: pop, take the value, then wait for the output register to drain
// synchronous active-high reset clears count, flags and control; no clearing pass
`default_nettype none

module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pse_req_if.sink    token,
  pse_res_if.source  result
);

  pse_cmd_t    cmd;
  pse_status_t status;

  // sequencer: owns token ready, steps the datapath
  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (token.valid),
    .in_ready (token.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // stack, flags, arithmetic and result register
  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (token.req_type),
    .operator_code (token.operator_code),
    .operand_value (token.operand_value),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

endmodule

`default_nettype wire
